@@ rtl/core/mclp_pkg.sv @@
// package for the move command line parser
// request and result payload types, status codes and character constants
// no dependencies
`default_nettype none

package mclp_pkg;

  localparam int unsigned HOLD_W  = 24;
  localparam int unsigned POWER_W = 32;

  // request kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_UNKNOWN    = 2'd0;
  localparam logic [1:0] STATUS_EXECUTED   = 2'd1;
  localparam logic [1:0] STATUS_SUPPRESSED = 2'd2;

  // characters
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] KEYWORD_C0   = 8'h4D;  // M
  localparam logic [7:0] KEYWORD_C1   = 8'h56;  // V

  // number conversion phase, one-hot
  typedef enum logic [2:0] {
    PHASE_SKIP = 3'b001,
    PHASE_NUM  = 3'b010,
    PHASE_STOP = 3'b100
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [POWER_W-1:0] left_power;
    logic signed [POWER_W-1:0] right_power;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/move_command_line_parser.sv @@
// move command line parser, top level
// parses "MV <left> <right>" lines from a byte stream and gates moves by tick hold-off
// depends on mclp_pkg
//
// usage:
//   request channel (item_valid / item_stall / item) carries either one received
//   byte or one time tick. a request is taken whenever item_stall is low; a newline
//   byte produces one result on the result channel (result_valid / result_stall /
//   result) via the output register, or the skid register while the receiver stalls;
//   other requests produce none. throughput is one request per cycle while item_stall
//   is low: the per-byte parse (keyword match, decimal accumulate by shift-add) is
//   one short combinational step on the running line state.
//   results go to an output register backed by a one-entry skid register, so
//   requests keep flowing while a result waits. item_stall rises only when the
//   skid register is occupied, i.e. after the receiver has stalled a waiting
//   result and another result was produced behind it.
//   hold_off_we writes hold_off_wdata into the hold-off register at the clock
//   edge; write it only while the block is idle.
//   rst (synchronous) clears the line state, tick counter and hold-off and empties
//   both result registers; the block accepts requests in the first cycle after it.
`default_nettype none

module move_command_line_parser (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               item_valid,
  output logic                              item_stall,
  input  wire mclp_pkg::item_t              item,
  output logic                              result_valid,
  input  wire                               result_stall,
  output mclp_pkg::result_t                 result,
  input  wire                               hold_off_we,
  input  wire [mclp_pkg::HOLD_W-1:0]        hold_off_wdata
);

  localparam int unsigned PW = mclp_pkg::POWER_W;
  localparam int unsigned HW = mclp_pkg::HOLD_W;

  // configuration and running state
  logic [HW-1:0]    hold_off_ticks;
  logic [HW-1:0]    elapsed_ticks, elapsed_ticks_next;
  logic [1:0]       token_index, token_index_next;
  logic             in_token, in_token_next;
  logic [1:0]       keyword_progress, keyword_progress_next;
  logic             keyword_mismatch, keyword_mismatch_next;
  mclp_pkg::phase_t number_phase, number_phase_next;
  logic             number_negative, number_negative_next;
  logic [PW-1:0]    number_value, number_value_next;
  logic [PW-1:0]    first_value, first_value_next;

  // result side
  mclp_pkg::result_t skid;
  logic              skid_full;
  mclp_pkg::result_t new_result;
  logic              new_result_valid;

  logic       accept;
  logic       out_ready;
  logic [7:0] c;
  logic       is_digit;
  logic       is_space;
  logic [PW-1:0] digit_value;
  logic [PW-1:0] signed_now;
  logic [7:0] keyword_char;

  assign item_stall  = skid_full;
  assign accept      = item_valid && !item_stall;
  assign out_ready   = !result_valid || !result_stall;

  assign c           = item.byte_value;
  assign is_digit    = (c >= mclp_pkg::CHAR_ZERO) && (c <= mclp_pkg::CHAR_NINE);
  assign is_space    = (c == mclp_pkg::CHAR_SPACE) ||
                       ((c >= mclp_pkg::CHAR_TAB) && (c <= mclp_pkg::CHAR_CR));
  assign digit_value = {{(PW-4){1'b0}}, c[3:0]};
  assign keyword_char = keyword_progress[0] ? mclp_pkg::KEYWORD_C1 : mclp_pkg::KEYWORD_C0;
  assign signed_now  = number_negative ? (PW'(0) - number_value) : number_value;

  always_comb begin
    elapsed_ticks_next    = elapsed_ticks;
    token_index_next      = token_index;
    in_token_next         = in_token;
    keyword_progress_next = keyword_progress;
    keyword_mismatch_next = keyword_mismatch;
    number_phase_next     = number_phase;
    number_negative_next  = number_negative;
    number_value_next     = number_value;
    first_value_next      = first_value;
    new_result_valid      = 1'b0;
    new_result.status      = mclp_pkg::STATUS_UNKNOWN;
    new_result.left_power  = '0;
    new_result.right_power = '0;

    if (accept) begin
      if (item.cmd == mclp_pkg::CMD_TICK) begin
        if (elapsed_ticks < hold_off_ticks) begin
          elapsed_ticks_next = elapsed_ticks + HW'(1);
        end
      end else if (c == mclp_pkg::CHAR_SPACE) begin
        if (in_token) begin
          if (token_index == 2'd1) begin
            first_value_next = signed_now;
          end
          if (token_index != 2'd3) begin
            token_index_next = token_index + 2'd1;
          end
          in_token_next = 1'b0;
        end
      end else begin
        // token start resets the number converter for parameter tokens
        if (!in_token && (token_index == 2'd1 || token_index == 2'd2)) begin
          number_phase_next    = mclp_pkg::PHASE_SKIP;
          number_negative_next = 1'b0;
          number_value_next    = '0;
        end
        in_token_next = 1'b1;

        if (token_index == 2'd0) begin
          if (keyword_progress != 2'd2 && c == keyword_char) begin
            keyword_progress_next = keyword_progress + 2'd1;
          end else begin
            keyword_mismatch_next = 1'b1;
          end
        end else if (token_index != 2'd3) begin
          unique case (number_phase_next)
            mclp_pkg::PHASE_SKIP: begin
              if (is_space) begin
                number_phase_next = mclp_pkg::PHASE_SKIP;
              end else if (c == mclp_pkg::CHAR_PLUS || c == mclp_pkg::CHAR_MINUS) begin
                number_negative_next = (c == mclp_pkg::CHAR_MINUS);
                number_phase_next    = mclp_pkg::PHASE_NUM;
              end else if (is_digit) begin
                number_value_next = digit_value;
                number_phase_next = mclp_pkg::PHASE_NUM;
              end else begin
                number_phase_next = mclp_pkg::PHASE_STOP;
              end
            end
            mclp_pkg::PHASE_NUM: begin
              if (is_digit) begin
                // times ten by shift-add, wraps modulo 2^32
                number_value_next = (number_value_next << 3) + (number_value_next << 1)
                                    + digit_value;
              end else begin
                number_phase_next = mclp_pkg::PHASE_STOP;
              end
            end
            mclp_pkg::PHASE_STOP: begin
              number_phase_next = mclp_pkg::PHASE_STOP;
            end
            default: begin
              number_phase_next = mclp_pkg::PHASE_STOP;
            end
          endcase
        end

        if (c == mclp_pkg::CHAR_NEWLINE) begin
          new_result_valid = 1'b1;
          if (keyword_progress_next == 2'd2 && !keyword_mismatch_next) begin
            if (token_index == 2'd1) begin
              new_result.left_power = number_negative_next ?
                                      (PW'(0) - number_value_next) : number_value_next;
            end else if (token_index != 2'd0) begin
              new_result.left_power  = first_value;
              new_result.right_power = number_negative_next ?
                                       (PW'(0) - number_value_next) : number_value_next;
            end
            if (elapsed_ticks >= hold_off_ticks) begin
              new_result.status  = mclp_pkg::STATUS_EXECUTED;
              elapsed_ticks_next = '0;
            end else begin
              new_result.status  = mclp_pkg::STATUS_SUPPRESSED;
            end
          end
          // line done
          token_index_next      = 2'd0;
          in_token_next         = 1'b0;
          keyword_progress_next = 2'd0;
          keyword_mismatch_next = 1'b0;
          number_phase_next     = mclp_pkg::PHASE_SKIP;
          number_negative_next  = 1'b0;
          number_value_next     = '0;
          first_value_next      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_off_ticks   <= '0;
      elapsed_ticks    <= '0;
      token_index      <= 2'd0;
      in_token         <= 1'b0;
      keyword_progress <= 2'd0;
      keyword_mismatch <= 1'b0;
      number_phase     <= mclp_pkg::PHASE_SKIP;
      number_negative  <= 1'b0;
      number_value     <= '0;
      first_value      <= '0;
    end else begin
      if (hold_off_we) begin
        hold_off_ticks <= hold_off_wdata;
      end
      elapsed_ticks    <= elapsed_ticks_next;
      token_index      <= token_index_next;
      in_token         <= in_token_next;
      keyword_progress <= keyword_progress_next;
      keyword_mismatch <= keyword_mismatch_next;
      number_phase     <= number_phase_next;
      number_negative  <= number_negative_next;
      number_value     <= number_value_next;
      first_value      <= first_value_next;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (out_ready) begin
      if (skid_full) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end else begin
        result_valid <= new_result_valid;
      end
    end else if (new_result_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      if (skid_full) begin
        result <= skid;
      end else if (new_result_valid) begin
        result <= new_result;
      end
    end else if (new_result_valid) begin
      skid <= new_result;
    end
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for move_command_line_parser: directed table, then random phases
// an in-bench predictor of the line parser and tick hold-off, or a result pinned in the table, checks every result
// depends on mclp_pkg and rtl/core/move_command_line_parser.sv
`timescale 1ns / 100ps

module testbench;

  typedef enum logic [1:0] {ROW_LINE, ROW_TICKS, ROW_HOLD} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    string              text;
    int unsigned        count;   // tick count or hold-off value
    bit                 pinned;  // result typed in below instead of predicted
    mclp_pkg::result_t  want;
  } stim_row_t;

  typedef struct packed {
    logic              pinned;
    mclp_pkg::result_t want;
  } line_pin_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  mclp_pkg::item_t               req = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  mclp_pkg::result_t             res;
  logic                          hold_off_we = 1'b0;
  logic [mclp_pkg::HOLD_W-1:0]   hold_off_wdata = '0;

  // parser model state
  logic [mclp_pkg::HOLD_W-1:0]   hold_off = '0;
  logic [mclp_pkg::HOLD_W-1:0]   elapsed = '0;
  logic [1:0]                    tok_idx = '0;
  logic                          in_tok = 1'b0;
  logic [1:0]                    kw_prog = '0;
  logic                          kw_bad = 1'b0;
  mclp_pkg::phase_t              num_phase = mclp_pkg::PHASE_SKIP;
  logic                          num_neg = 1'b0;
  logic [mclp_pkg::POWER_W-1:0]  num_mag = '0;
  logic [mclp_pkg::POWER_W-1:0]  first_param = '0;

  mclp_pkg::result_t   expected_results[$];
  line_pin_t           pinned_results[$];
  int unsigned         mismatches = 0;
  int unsigned         items_sent = 0;
  bit                  tx_gaps_on = 1'b1;
  bit                  rx_gaps_on = 1'b1;
  int unsigned         rx_hold_request = 0;

  stim_row_t directed_rows [28] = '{
    '{ROW_LINE, "MV 12 -34\n", 0, 1'b1, '{mclp_pkg::STATUS_EXECUTED, 32'sd12, -32'sd34}},
    '{ROW_LINE, "MV\n", 0, 1'b1, '{mclp_pkg::STATUS_UNKNOWN, 32'sd0, 32'sd0}},
    '{ROW_LINE, "\n", 0, 1'b1, '{mclp_pkg::STATUS_UNKNOWN, 32'sd0, 32'sd0}},
    '{ROW_LINE, "   \n", 0, 1'b1, '{mclp_pkg::STATUS_UNKNOWN, 32'sd0, 32'sd0}},
    '{ROW_LINE, "MX 1 2\n", 0, 1'b1, '{mclp_pkg::STATUS_UNKNOWN, 32'sd0, 32'sd0}},
    '{ROW_LINE, "MVV 1 2\n", 0, 1'b1, '{mclp_pkg::STATUS_UNKNOWN, 32'sd0, 32'sd0}},
    '{ROW_LINE, "mv 1 2\n", 0, 1'b1, '{mclp_pkg::STATUS_UNKNOWN, 32'sd0, 32'sd0}},
    '{ROW_LINE, "MV 7\n", 0, 1'b1, '{mclp_pkg::STATUS_EXECUTED, 32'sd7, 32'sd0}},
    '{ROW_LINE, "MV \n", 0, 1'b0, '0},
    '{ROW_LINE, "MV 2147483647 -2147483648\n", 0, 1'b1,
      '{mclp_pkg::STATUS_EXECUTED, 32'sh7fffffff, 32'sh80000000}},
    '{ROW_LINE, "MV 4294967301 -4294967297\n", 0, 1'b0, '0},
    '{ROW_LINE, "MV \011\015\013\014+42 -\0119\n", 0, 1'b0, '0},
    '{ROW_LINE, "MV 1 2 3 4\n", 0, 1'b1, '{mclp_pkg::STATUS_EXECUTED, 32'sd1, 32'sd2}},
    '{ROW_LINE, "MV  3   4\n", 0, 1'b0, '0},
    '{ROW_LINE, "MV 12abc 9x\n", 0, 1'b0, '0},
    '{ROW_LINE, "MV +-5 --3\n", 0, 1'b0, '0},
    '{ROW_LINE, "\377\200 MV\n", 0, 1'b1, '{mclp_pkg::STATUS_UNKNOWN, 32'sd0, 32'sd0}},
    '{ROW_TICKS, "", 3, 1'b0, '0},
    '{ROW_HOLD, "", 3, 1'b0, '0},
    '{ROW_LINE, "MV 1 1\n", 0, 1'b1, '{mclp_pkg::STATUS_SUPPRESSED, 32'sd1, 32'sd1}},
    '{ROW_TICKS, "", 5, 1'b0, '0},
    '{ROW_LINE, "MV 9 9\n", 0, 1'b1, '{mclp_pkg::STATUS_EXECUTED, 32'sd9, 32'sd9}},
    '{ROW_TICKS, "", 2, 1'b0, '0},
    '{ROW_LINE, "MV -2 -2\n", 0, 1'b0, '0},
    '{ROW_HOLD, "", 24'hFFFFFF, 1'b0, '0},
    '{ROW_TICKS, "", 4, 1'b0, '0},
    // hold-off lowered below the running count
    '{ROW_HOLD, "", 1, 1'b0, '0},
    '{ROW_LINE, "MV -1 -1\n", 0, 1'b0, '0}
  };

  move_command_line_parser dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (req_valid),
    .item_stall     (req_stall),
    .item           (req),
    .result_valid   (res_valid),
    .result_stall   (res_stall),
    .result         (res),
    .hold_off_we    (hold_off_we),
    .hold_off_wdata (hold_off_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [mclp_pkg::POWER_W-1:0] signed_magnitude();
    return num_neg ? -num_mag : num_mag;
  endfunction

  // advances the parser model by one request, returns 1 when a line result is due
  function automatic bit parse_request(input mclp_pkg::item_t r,
                                       output mclp_pkg::result_t line_res);
    logic [7:0] ch;
    logic       is_digit;
    logic       is_space;
    ch = r.byte_value;
    line_res = '0;
    if (r.cmd == mclp_pkg::CMD_TICK) begin
      if (elapsed < hold_off) elapsed = elapsed + 1'b1;
      return 1'b0;
    end
    if (ch == mclp_pkg::CHAR_SPACE) begin
      if (in_tok) begin
        if (tok_idx == 2'd1) first_param = signed_magnitude();
        if (tok_idx != 2'd3) tok_idx = tok_idx + 1'b1;
        in_tok = 1'b0;
      end
      return 1'b0;
    end
    if (!in_tok) begin
      in_tok = 1'b1;
      if (tok_idx == 2'd1 || tok_idx == 2'd2) begin
        num_phase = mclp_pkg::PHASE_SKIP;
        num_neg = 1'b0;
        num_mag = '0;
      end
    end
    is_digit = (ch >= mclp_pkg::CHAR_ZERO) && (ch <= mclp_pkg::CHAR_NINE);
    // atoi skips space, tab, newline, vertical tab, form feed, carriage return
    is_space = (ch == mclp_pkg::CHAR_SPACE) ||
               (ch >= mclp_pkg::CHAR_TAB && ch <= mclp_pkg::CHAR_CR);
    if (tok_idx == 2'd0) begin
      if (kw_prog == 2'd0 && ch == mclp_pkg::KEYWORD_C0) kw_prog = 2'd1;
      else if (kw_prog == 2'd1 && ch == mclp_pkg::KEYWORD_C1) kw_prog = 2'd2;
      else kw_bad = 1'b1;
    end else if (tok_idx != 2'd3) begin
      case (num_phase)
        mclp_pkg::PHASE_SKIP: begin
          if (!is_space) begin
            if (ch == mclp_pkg::CHAR_PLUS || ch == mclp_pkg::CHAR_MINUS) begin
              num_neg = (ch == mclp_pkg::CHAR_MINUS);
              num_phase = mclp_pkg::PHASE_NUM;
            end else if (is_digit) begin
              num_mag = {24'd0, ch - mclp_pkg::CHAR_ZERO};
              num_phase = mclp_pkg::PHASE_NUM;
            end else begin
              num_phase = mclp_pkg::PHASE_STOP;
            end
          end
        end
        mclp_pkg::PHASE_NUM: begin
          if (is_digit) num_mag = num_mag * 32'd10 + {24'd0, ch - mclp_pkg::CHAR_ZERO};
          else num_phase = mclp_pkg::PHASE_STOP;
        end
        default: begin
        end
      endcase
    end
    if (ch != mclp_pkg::CHAR_NEWLINE) return 1'b0;

    if (kw_prog == 2'd2 && !kw_bad) begin
      if (tok_idx == 2'd1) begin
        line_res.left_power = signed_magnitude();
      end else if (tok_idx >= 2'd2) begin
        line_res.left_power = first_param;
        line_res.right_power = signed_magnitude();
      end
      if (elapsed >= hold_off) begin
        line_res.status = mclp_pkg::STATUS_EXECUTED;
        elapsed = '0;
      end else begin
        line_res.status = mclp_pkg::STATUS_SUPPRESSED;
      end
    end else begin
      line_res.status = mclp_pkg::STATUS_UNKNOWN;
    end
    tok_idx = '0;
    in_tok = 1'b0;
    kw_prog = '0;
    kw_bad = 1'b0;
    num_phase = mclp_pkg::PHASE_SKIP;
    num_neg = 1'b0;
    num_mag = '0;
    first_param = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : request_monitor
    mclp_pkg::result_t predicted;
    line_pin_t         pin;
    if (!rst && req_valid && !req_stall) begin
      if (parse_request(req, predicted)) begin
        if (pinned_results.size() != 0) begin
          pin = pinned_results.pop_front();
          if (pin.pinned) predicted = pin.want;
        end
        expected_results = {expected_results, predicted};
      end
    end
  end

  always @(posedge clk) begin : result_checker
    mclp_pkg::result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d left %0d right %0d",
                 $time, res.status, res.left_power, res.right_power);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (res.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, res.status);
          mismatches++;
        end
        if (res.left_power !== want.left_power) begin
          $display("%0t: left_power expected %0d, got %0d",
                   $time, want.left_power, res.left_power);
          mismatches++;
        end
        if (res.right_power !== want.right_power) begin
          $display("%0t: right_power expected %0d, got %0d",
                   $time, want.right_power, res.right_power);
          mismatches++;
        end
      end
    end
  end

  // result receiver: random stall per result, plus a long hold on demand
  initial begin : result_receiver
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (res_valid && !res_stall) stall_left = rx_gaps_on ? $urandom_range(0, 7) : 0;
      if (rx_hold_request != 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // called at a clock edge; returns at the edge where the request is taken
  task automatic offer(input logic kind, input logic [7:0] value);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{kind, value};
    items_sent++;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(mclp_pkg::CMD_BYTE, s[i]);
  endtask

  task automatic send_ticks(input int unsigned n);
    // byte field carries junk, newlines included, which the block must ignore
    repeat (n) offer(mclp_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold_off(input logic [mclp_pkg::HOLD_W-1:0] value);
    wait_drained();
    hold_off_we <= 1'b1;
    hold_off_wdata <= value;
    @(posedge clk);
    hold_off_we <= 1'b0;
    hold_off = value;
  endtask

  function automatic string random_move_line();
    string line;
    string sep;
    string num;
    int unsigned params;
    case ($urandom_range(0, 9))
      0: line = "M";
      1: line = "MVM";
      2: line = "mV";
      default: line = "MV";
    endcase
    params = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 2;
    for (int p = 0; p < params; p++) begin
      if ($urandom_range(0, 3) == 0) sep = "  ";
      else sep = " ";
      case ($urandom_range(0, 7))
        0: num = $sformatf("%0d", $signed($urandom()));
        1: num = $sformatf("%0d%0d", $urandom_range(1, 9), $urandom());
        2: num = $sformatf("\011+%0d", $urandom_range(0, 999));
        3: num = $sformatf("%0dq", $urandom_range(0, 99));
        4: num = "-";
        default: num = $sformatf("%0d", int'($urandom_range(0, 200)) - 100);
      endcase
      line = {line, sep, num};
    end
    if ($urandom_range(0, 7) == 0) line = {line, " "};
    return {line, "\n"};
  endfunction

  initial begin : stimulus
    line_pin_t                   pin;
    logic [mclp_pkg::HOLD_W-1:0] phase_hold [6];
    int unsigned                 phase_end;
    int unsigned                 pick;
    phase_hold[0] = '0;
    phase_hold[1] = 24'hFFFFFF;
    phase_hold[2] = 24'd2;
    phase_hold[3] = mclp_pkg::HOLD_W'($urandom_range(1, 8));
    phase_hold[4] = mclp_pkg::HOLD_W'($urandom());
    phase_hold[5] = 24'd1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_LINE: begin
          pin.pinned = directed_rows[i].pinned;
          pin.want = directed_rows[i].want;
          pinned_results = {pinned_results, pin};
          send_text(directed_rows[i].text);
        end
        ROW_TICKS: send_ticks(directed_rows[i].count);
        default: write_hold_off(mclp_pkg::HOLD_W'(directed_rows[i].count));
      endcase
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_hold_off(phase_hold[ph]);
      tx_gaps_on = (ph != 3);
      rx_gaps_on = (ph != 3) && (ph != 2);
      // receiver holds off while short lines keep coming, so the block backs up
      if (ph == 2) rx_hold_request = 100;
      phase_end = items_sent + 95;
      while (items_sent < phase_end) begin
        if (ph == 4 && items_sent + 70 >= phase_end && items_sent + 60 < phase_end)
          wait_drained();
        if ($urandom_range(0, 2) == 0) send_ticks($urandom_range(1, 6));
        pick = $urandom_range(0, 9);
        if (ph == 2) begin
          if (pick < 4) send_text("\n");
          else send_text($sformatf("MV %0d\n", $urandom_range(0, 9)));
        end else if (pick < 7) begin
          send_text(random_move_line());
        end else begin
          repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(0, 7) == 0) offer(mclp_pkg::CMD_BYTE, 8'h00);
            else offer(mclp_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
          end
          offer(mclp_pkg::CMD_BYTE, mclp_pkg::CHAR_NEWLINE);
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
